// File: sv/cmfp_pkg.sv
// Package with the types, constants and register codes of the client message field parser.
`timescale 1ns / 1ps

package cmfp_pkg;

    localparam logic [7:0]  VERSION_BYTE   = 8'h35;
    localparam logic [7:0]  SEPARATOR_BYTE = 8'h7C;
    localparam logic [7:0]  LINE_FEED      = 8'h0A;
    localparam logic [10:0] INDEX_LIMIT    = 11'd1024;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] CFG_MSG_END     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NL_STAND_IN = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_USER    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MSG     = 8'd3;

    typedef enum logic [1:0] {
        PH_VERSION = 2'd0,
        PH_USER    = 2'd1,
        PH_MSG     = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_VERSION    = 3'd1,
        ERR_USER_LONG  = 3'd2,
        ERR_MSG_LONG   = 3'd3,
        ERR_AFTER_DONE = 3'd4
    } t_err;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_USER = 2'd1;
    localparam logic [1:0] KIND_MSG  = 2'd2;

    localparam logic [1:0] STAT_PARSING = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_ERROR   = 2'd2;

    typedef struct packed {
        logic [7:0]  msg_end_byte;
        logic [7:0]  newline_stand_in;
        logic [7:0]  max_username_len;
        logic [10:0] max_message_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] char_kind;
        logic [7:0] char_out;
        logic [9:0] char_index;
        logic [1:0] parse_status;
        logic [2:0] error_code;
    } t_result;

endpackage

// File: sv/cmfp_cfg.sv
// Configuration registers of the client message field parser.
`timescale 1ns / 1ps

module cmfp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [cmfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cmfp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cmfp_pkg::t_cfg                   o_cfg
);
    import cmfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msg_end_byte     <= 8'd10;
            r_cfg.newline_stand_in <= 8'd126;
            r_cfg.max_username_len <= 8'd255;
            r_cfg.max_message_len  <= 11'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MSG_END:     r_cfg.msg_end_byte     <= i_cfg_data[7:0];
                CFG_NL_STAND_IN: r_cfg.newline_stand_in <= i_cfg_data[7:0];
                CFG_MAX_USER:    r_cfg.max_username_len <= i_cfg_data[7:0];
                CFG_MAX_MSG:     r_cfg.max_message_len  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/cmfp_in_reg.sv
// Input register stage that holds one accepted byte until the parser takes it.
`timescale 1ns / 1ps

module cmfp_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cmfp_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output cmfp_pkg::t_item o_item
);
    import cmfp_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The stage refills in the same cycle that its byte moves on.
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/cmfp_core.sv
// Parser state machine, field counters and per-byte result logic.
`timescale 1ns / 1ps

module cmfp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  cmfp_pkg::t_item   i_item,
    input  cmfp_pkg::t_cfg    i_cfg,
    output cmfp_pkg::t_result o_result
);
    import cmfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_user_cnt, n_user_cnt;
    logic [10:0] r_msg_cnt, n_msg_cnt;
    t_err        r_err, n_err;

    t_phase      cur_phase;
    logic [7:0]  cur_user_cnt;
    logic [10:0] cur_msg_cnt;
    t_err        cur_err;
    logic [10:0] msg_limit;
    logic        user_full;
    logic        msg_full;

    // A first byte clears everything before it is checked as the version.
    always_comb begin
        cur_phase    = i_item.first_byte ? PH_VERSION : r_phase;
        cur_user_cnt = i_item.first_byte ? 8'd0 : r_user_cnt;
        cur_msg_cnt  = i_item.first_byte ? 11'd0 : r_msg_cnt;
        cur_err      = i_item.first_byte ? ERR_NONE : r_err;
    end

    assign msg_limit = (i_cfg.max_message_len > INDEX_LIMIT) ? INDEX_LIMIT
                                                             : i_cfg.max_message_len;
    assign user_full = cur_user_cnt >= i_cfg.max_username_len;
    assign msg_full  = cur_msg_cnt >= msg_limit;

    // Next phase.
    always_comb begin
        n_phase = cur_phase;
        if (cur_err == ERR_NONE) begin
            case (cur_phase)
                PH_VERSION: begin
                    if (i_item.data_byte == VERSION_BYTE) n_phase = PH_USER;
                end
                PH_USER: begin
                    if (i_item.data_byte == SEPARATOR_BYTE) n_phase = PH_MSG;
                end
                PH_MSG: begin
                    if (i_item.data_byte == i_cfg.msg_end_byte) n_phase = PH_DONE;
                end
                default: n_phase = cur_phase;
            endcase
        end
    end

    // Counters, held error and the result of this byte.
    always_comb begin
        n_user_cnt          = cur_user_cnt;
        n_msg_cnt           = cur_msg_cnt;
        n_err               = cur_err;
        o_result.char_kind  = KIND_NONE;
        o_result.char_out   = 8'd0;
        o_result.char_index = 10'd0;
        if (cur_err == ERR_NONE) begin
            case (cur_phase)
                PH_VERSION: begin
                    if (i_item.data_byte != VERSION_BYTE) n_err = ERR_VERSION;
                end
                PH_USER: begin
                    if (i_item.data_byte != SEPARATOR_BYTE) begin
                        if (user_full) begin
                            n_err = ERR_USER_LONG;
                        end else begin
                            o_result.char_kind  = KIND_USER;
                            o_result.char_out   = i_item.data_byte;
                            o_result.char_index = {2'b00, cur_user_cnt};
                            n_user_cnt          = cur_user_cnt + 8'd1;
                        end
                    end
                end
                PH_MSG: begin
                    if (i_item.data_byte != i_cfg.msg_end_byte) begin
                        if (msg_full) begin
                            n_err = ERR_MSG_LONG;
                        end else begin
                            o_result.char_kind  = KIND_MSG;
                            o_result.char_out   =
                                (i_item.data_byte == i_cfg.newline_stand_in) ? LINE_FEED
                                                                             : i_item.data_byte;
                            o_result.char_index = cur_msg_cnt[9:0];
                            n_msg_cnt           = cur_msg_cnt + 11'd1;
                        end
                    end
                end
                default: n_err = ERR_AFTER_DONE;
            endcase
        end
        if (n_err != ERR_NONE) begin
            o_result.parse_status = STAT_ERROR;
        end else if (n_phase == PH_DONE) begin
            o_result.parse_status = STAT_DONE;
        end else begin
            o_result.parse_status = STAT_PARSING;
        end
        o_result.error_code = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VERSION;
            r_user_cnt <= 8'd0;
            r_msg_cnt  <= 11'd0;
            r_err      <= ERR_NONE;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_user_cnt <= n_user_cnt;
            r_msg_cnt  <= n_msg_cnt;
            r_err      <= n_err;
        end
    end

endmodule

// File: sv/cmfp_out_reg.sv
// Result register that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module cmfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cmfp_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output cmfp_pkg::t_result o_result
);
    import cmfp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: sv/client_message_field_parser_top.sv
// Top level of the client message field parser.
//
// Input channel: i_in_valid / o_in_ready carry one stream byte (i_data_byte) and a
// restart flag (i_first_byte) per transfer. A byte with i_first_byte set clears the
// parser and is checked as the version byte.
// Output channel: o_out_valid / i_out_ready carry one result per input byte: the
// extracted character with its kind and field position, the parse status and the
// held error code.
// Configuration channel: i_cfg_valid / o_cfg_ready write register i_cfg_index with
// i_cfg_data (0 end token, 1 newline stand-in, 2 username limit, 3 message limit).
// Other indexes are ignored. The port is always ready.
// Path: a byte is held in the input register, the parser works on it combinationally
// and the result register captures its result. Throughput is one byte per cycle
// while the receiver does not stall; parser state updates between the two registers.
// Reset clears the parser to the version check, empties both registers and loads
// the register defaults. When the receiver stalls, the result register holds, then
// the input register fills, and o_in_ready falls; no transfer is lost.
`timescale 1ns / 1ps

module client_message_field_parser_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_char_kind,
    output logic [7:0]                       o_char_out,
    output logic [9:0]                       o_char_index,
    output logic [1:0]                       o_parse_status,
    output logic [2:0]                       o_error_code,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cmfp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cmfp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cmfp_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_slot_free;
    logic    go;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    cmfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_item.data_byte  = i_data_byte;
    assign in_item.first_byte = i_first_byte;

    cmfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (go),
        .o_item  (held_item)
    );

    // The parser advances exactly when a held byte can move into the result register.
    assign go = held_valid && out_slot_free;

    cmfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_item   (held_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    cmfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (held_valid),
        .o_ready  (out_slot_free),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_char_kind    = out_result.char_kind;
    assign o_char_out     = out_result.char_out;
    assign o_char_index   = out_result.char_index;
    assign o_parse_status = out_result.parse_status;
    assign o_error_code   = out_result.error_code;

endmodule
